// ----- rtl/core/pidff_pkg.sv -----
`default_nettype none

package pidff_pkg;

	// Field widths
	localparam int GAIN_W  = 24;
	localparam int DATA_W  = 32;
	localparam int CFG_IDX_W = 3;

	// Internal datapath widths
	localparam int ERR_W   = DATA_W + 1;           // setpoint - measured
	localparam int DELTA_W = ERR_W + 1;            // error difference
	localparam int FRAC_W  = 16;                   // Q.16 scaling
	localparam int PPROD_W = ERR_W + GAIN_W + 1;   // signed err * unsigned gain
	localparam int DPROD_W = DELTA_W + GAIN_W + 1;
	localparam int PTERM_W = PPROD_W - FRAC_W;
	localparam int DTERM_W = DPROD_W - FRAC_W;
	localparam int INTEG_W = 48;
	localparam int PDF_W   = DTERM_W + 2;          // P + D + feedforward
	localparam int SUM_W   = INTEG_W + 1;          // full output sum

	// Reset values of the limits: 1000.0 and 150.0 in Q16.16
	localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd65536000;
	localparam logic signed [DATA_W-1:0] FLOOR_RESET = 32'sd9830400;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP          = 3'd0,
		REG_KI          = 3'd1,
		REG_KD          = 3'd2,
		REG_UPPER_LIMIT = 3'd3,
		REG_LOWER_FLOOR = 3'd4,
		REG_DERIV_MODE  = 3'd5,
		REG_FIXED_DELTA = 3'd6
	} cfg_reg_t;

	// Item commands
	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Derivative modes
	localparam logic MODE_SPEED = 1'b0;
	localparam logic MODE_ANGLE = 1'b1;

	// Clamp status codes
	typedef enum logic [1:0] {
		LIM_NONE  = 2'd0,
		LIM_CEIL  = 2'd1,
		LIM_FLOOR = 2'd2
	} limit_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        kp;
		logic [GAIN_W-1:0]        ki;
		logic [GAIN_W-1:0]        kd;
		logic signed [DATA_W-1:0] upper_limit;
		logic signed [DATA_W-1:0] lower_floor;
		logic                     derivative_mode;
		logic signed [DATA_W-1:0] fixed_delta;
	} cfg_t;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] measured;
		logic signed [DATA_W-1:0] feedforward;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic [1:0]               limit_hit;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/pidff_cfg.sv -----
`default_nettype none

module pidff_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [pidff_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire  [pidff_pkg::DATA_W-1:0]        cfg_wdata,
	output pidff_pkg::cfg_t                     cfg
);

	pidff_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp              <= '0;
			cfg_q.ki              <= '0;
			cfg_q.kd              <= '0;
			cfg_q.upper_limit     <= pidff_pkg::UPPER_RESET;
			cfg_q.lower_floor     <= pidff_pkg::FLOOR_RESET;
			cfg_q.derivative_mode <= pidff_pkg::MODE_SPEED;
			cfg_q.fixed_delta     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pidff_pkg::REG_KP:          cfg_q.kp <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
				pidff_pkg::REG_KI:          cfg_q.ki <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
				pidff_pkg::REG_KD:          cfg_q.kd <= cfg_wdata[pidff_pkg::GAIN_W-1:0];
				pidff_pkg::REG_UPPER_LIMIT: cfg_q.upper_limit <= $signed(cfg_wdata);
				pidff_pkg::REG_LOWER_FLOOR: cfg_q.lower_floor <= $signed(cfg_wdata);
				pidff_pkg::REG_DERIV_MODE:  cfg_q.derivative_mode <= cfg_wdata[0];
				pidff_pkg::REG_FIXED_DELTA: cfg_q.fixed_delta <= $signed(cfg_wdata);
				default: ; // unmapped index: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/pid_feedforward_controller.sv -----
// Positional PID step with feedforward, signed Q16.16, four register stages.
// A step item goes through the stage 1, 2 and 3 registers to the output register
// and is shown on out_item until taken. Throughput: one item per cycle while
// out_stall holds nothing back; the integral update is a loop closed in stage 3.
// Clear items take a slot but give no result. Reset (arst_n low): gains 0, limits
// 1000.0 / 150.0, speed mode, integral and previous error zero, pipeline empty.
`default_nettype none

module pid_feedforward_controller (
	input  wire                              clk,
	input  wire                              arst_n,
	// step items
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  pidff_pkg::in_item_t        in_item,
	// results
	output logic                             out_valid,
	input  wire                              out_stall,
	output pidff_pkg::out_item_t             out_item,
	// configuration
	input  wire                              cfg_we,
	input  wire  [pidff_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire  [pidff_pkg::DATA_W-1:0]     cfg_wdata
);

	localparam int DW = pidff_pkg::DATA_W;
	localparam int EW = pidff_pkg::ERR_W;
	localparam int AW = pidff_pkg::DELTA_W;
	localparam int FW = pidff_pkg::FRAC_W;
	localparam int IW = pidff_pkg::INTEG_W;

	pidff_pkg::cfg_t cfg;

	pidff_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// ------------------------------------------------------------------
	// Flow control. Each stage moves when the one after it is empty or
	// moving, so bubbles collapse and input keeps flowing while a result
	// waits at the output, until the stages behind it have filled.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic out_valid_q;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;
	logic acc, mv1, mv2, mv3;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_out;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	assign acc = in_valid && rdy_s1;
	assign mv1 = v_s1 && rdy_s2;
	assign mv2 = v_s2 && rdy_s3;
	assign mv3 = v_s3 && rdy_out;

	// ------------------------------------------------------------------
	// Stage 1 (entry): error and derivative input. The previous error is
	// read and replaced here, in item order.
	// ------------------------------------------------------------------
	logic signed [EW-1:0] prev_err_q;
	logic signed [EW-1:0] err_in;
	logic signed [AW-1:0] delta_in;

	assign err_in = $signed({in_item.setpoint[DW-1], in_item.setpoint})
	              - $signed({in_item.measured[DW-1], in_item.measured});

	always_comb begin
		if (cfg.derivative_mode == pidff_pkg::MODE_ANGLE) begin
			delta_in = AW'(cfg.fixed_delta);
		end else begin
			delta_in = $signed({err_in[EW-1], err_in}) - $signed({prev_err_q[EW-1], prev_err_q});
		end
	end

	logic                 clr_s1;
	logic signed [EW-1:0] err_s1;
	logic signed [AW-1:0] delta_s1;
	logic signed [DW-1:0] ff_s1;

	// ------------------------------------------------------------------
	// Stage 2: the three gain products, floored to Q.16 by dropping the
	// low fraction bits (arithmetic shift rounds toward minus infinity).
	// ------------------------------------------------------------------
	logic signed [pidff_pkg::PPROD_W-1:0] p_prod, i_prod;
	logic signed [pidff_pkg::DPROD_W-1:0] d_prod;

	assign p_prod = err_s1 * $signed({1'b0, cfg.kp});
	assign i_prod = err_s1 * $signed({1'b0, cfg.ki});
	assign d_prod = delta_s1 * $signed({1'b0, cfg.kd});

	logic                                 clr_s2;
	logic signed [pidff_pkg::PTERM_W-1:0] p_s2, i_s2;
	logic signed [pidff_pkg::DTERM_W-1:0] d_s2;
	logic signed [DW-1:0]                 ff_s2;

	// ------------------------------------------------------------------
	// Stage 3: saturating integral update (its loop closes within this stage) and the
	// P + D + feedforward partial sum.
	// ------------------------------------------------------------------
	logic signed [IW-1:0] integ_q;
	logic signed [IW:0]   integ_raw;
	logic signed [IW-1:0] integ_sat;
	logic signed [pidff_pkg::PDF_W-1:0] pdf_s2;

	assign integ_raw = $signed({integ_q[IW-1], integ_q}) + (IW+1)'(i_s2);

	always_comb begin
		if (integ_raw[IW] != integ_raw[IW-1]) begin
			integ_sat = integ_raw[IW] ? pidff_pkg::INTEG_MIN : pidff_pkg::INTEG_MAX;
		end else begin
			integ_sat = integ_raw[IW-1:0];
		end
	end

	assign pdf_s2 = pidff_pkg::PDF_W'(p_s2) + pidff_pkg::PDF_W'(d_s2)
	              + pidff_pkg::PDF_W'(ff_s2);

	logic                               clr_s3;
	logic signed [pidff_pkg::PDF_W-1:0] pdf_s3;
	logic signed [IW-1:0]               integ_s3;

	// ------------------------------------------------------------------
	// Output: full sum, then ceiling check first and floor check second.
	// ------------------------------------------------------------------
	logic signed [pidff_pkg::SUM_W-1:0] sum_s3;
	logic signed [DW-1:0]               drive_d;
	pidff_pkg::limit_t                  hit_d;

	assign sum_s3 = pidff_pkg::SUM_W'(pdf_s3) + pidff_pkg::SUM_W'(integ_s3);

	always_comb begin
		if (sum_s3 > pidff_pkg::SUM_W'(cfg.upper_limit)) begin
			drive_d = cfg.upper_limit;
			hit_d   = pidff_pkg::LIM_CEIL;
		end else if (sum_s3 < pidff_pkg::SUM_W'(cfg.lower_floor)) begin
			drive_d = cfg.lower_floor;
			hit_d   = pidff_pkg::LIM_FLOOR;
		end else begin
			drive_d = sum_s3[DW-1:0];
			hit_d   = pidff_pkg::LIM_NONE;
		end
	end

	pidff_pkg::out_item_t out_q;

	// ------------------------------------------------------------------
	// Control state: valid bits and the two controller state registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			prev_err_q  <= '0;
			integ_q     <= '0;
		end else begin
			v_s1        <= acc || (v_s1 && !rdy_s2);
			v_s2        <= mv1 || (v_s2 && !rdy_s3);
			v_s3        <= mv2 || (v_s3 && !rdy_out);
			// clear items end here without a result
			out_valid_q <= (mv3 && (clr_s3 == pidff_pkg::CMD_STEP)) || (out_valid_q && out_stall);
			if (acc) begin
				prev_err_q <= (in_item.cmd == pidff_pkg::CMD_CLEAR) ? '0 : err_in;
			end
			if (mv2) begin
				integ_q <= (clr_s2 == pidff_pkg::CMD_CLEAR) ? '0 : integ_sat;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			clr_s1   <= in_item.cmd;
			err_s1   <= err_in;
			delta_s1 <= delta_in;
			ff_s1    <= in_item.feedforward;
		end
		if (mv1) begin
			clr_s2 <= clr_s1;
			p_s2   <= p_prod[pidff_pkg::PPROD_W-1:FW];
			i_s2   <= i_prod[pidff_pkg::PPROD_W-1:FW];
			d_s2   <= d_prod[pidff_pkg::DPROD_W-1:FW];
			ff_s2  <= ff_s1;
		end
		if (mv2) begin
			clr_s3   <= clr_s2;
			pdf_s3   <= pdf_s2;
			integ_s3 <= integ_sat;
		end
		if (mv3) begin
			out_q.drive     <= drive_d;
			out_q.limit_hit <= hit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ----- tb/pid_feedforward_controller_tb.sv -----
`timescale 1ns / 1ps

module pid_feedforward_controller_tb;

	// Run bounds. DRAIN_CYCLES quiet cycles after each phase let a trailing clear
	// item, which leaves no result to wait for, get out of the pipe.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PHASES = 12;

	// Index 7 exists on the port but maps to no register; writes must be dropped.
	localparam logic [pidff_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam logic [pidff_pkg::DATA_W-1:0] Q_MAX    = 32'h7FFF_FFFF;
	localparam logic [pidff_pkg::DATA_W-1:0] Q_MIN    = 32'h8000_0000;
	localparam logic [pidff_pkg::DATA_W-1:0] Q_ONE    = 32'h0001_0000;
	localparam logic [pidff_pkg::DATA_W-1:0] GAIN_MAX = 32'h00FF_FFFF;

	// Idle and stall percentages per phase: none, sender only, receiver only, both light.
	localparam int IDLE_MODE[4]  = '{0, 56, 0, 9};
	localparam int STALL_MODE[4] = '{0, 0, 56, 9};

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	pidff_pkg::in_item_t             in_item   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	pidff_pkg::out_item_t            out_item;
	logic                            cfg_we    = 1'b0;
	logic [pidff_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [pidff_pkg::DATA_W-1:0]    cfg_wdata = '0;

	pid_feedforward_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// Mirror of the register file, kept in 64-bit signed so every product and
	// the full P+I+D+FF sum are exact.
	longint gain_p      = 0;
	longint gain_i      = 0;
	longint gain_d      = 0;
	longint ceil_q      = longint'(pidff_pkg::UPPER_RESET);
	longint floor_q     = longint'(pidff_pkg::FLOOR_RESET);
	logic   angle_mode  = pidff_pkg::MODE_SPEED;
	longint delta_fixed = 0;

	// Controller state: Q32.16 integral (saturating at 48 bits) and last error.
	longint integ_acc = 0;
	longint last_err  = 0;

	pidff_pkg::in_item_t  step_queue[$];      // items waiting for the driver
	pidff_pkg::out_item_t drive_expected[$];  // predicted results, oldest first
	int          idle_pct   = 0;
	int          stall_pct  = 0;
	bit          item_taken = 1'b0;  // item accepted at the last rising edge
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// One controller step. Returns 1 when the item yields a result.
	function automatic bit advance_pid(input pidff_pkg::in_item_t it,
			output pidff_pkg::out_item_t res);
		longint err, dlt, p_term, d_term, total;
		res = '0;
		if (it.cmd == pidff_pkg::CMD_CLEAR) begin
			integ_acc = 0;
			last_err  = 0;
			return 1'b0;
		end
		err = longint'($signed(it.setpoint)) - longint'($signed(it.measured));
		// Angle mode swaps in the fixed delta but the last error still tracks.
		dlt = (angle_mode == pidff_pkg::MODE_ANGLE) ? delta_fixed : err - last_err;
		last_err = err;
		// >>> on signed 64-bit floors toward minus infinity, as the datapath does
		p_term = (err * gain_p) >>> pidff_pkg::FRAC_W;
		integ_acc = integ_acc + ((err * gain_i) >>> pidff_pkg::FRAC_W);
		if (integ_acc > longint'(pidff_pkg::INTEG_MAX))
			integ_acc = longint'(pidff_pkg::INTEG_MAX);
		else if (integ_acc < longint'(pidff_pkg::INTEG_MIN))
			integ_acc = longint'(pidff_pkg::INTEG_MIN);
		d_term = (dlt * gain_d) >>> pidff_pkg::FRAC_W;
		total = p_term + integ_acc + d_term + longint'($signed(it.feedforward));
		// Ceiling wins over floor, so an inverted pair still resolves
		if (total > ceil_q) begin
			res.drive     = ceil_q[pidff_pkg::DATA_W-1:0];
			res.limit_hit = pidff_pkg::LIM_CEIL;
		end else if (total < floor_q) begin
			res.drive     = floor_q[pidff_pkg::DATA_W-1:0];
			res.limit_hit = pidff_pkg::LIM_FLOOR;
		end else begin
			res.drive     = total[pidff_pkg::DATA_W-1:0];
			res.limit_hit = pidff_pkg::LIM_NONE;
		end
		return 1'b1;
	endfunction

	// Register write: one cycle of cfg_we, mirror updated alongside.
	task automatic write_reg(input logic [pidff_pkg::CFG_IDX_W-1:0] idx,
			input logic [pidff_pkg::DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			pidff_pkg::REG_KP:          gain_p = longint'(val[pidff_pkg::GAIN_W-1:0]);
			pidff_pkg::REG_KI:          gain_i = longint'(val[pidff_pkg::GAIN_W-1:0]);
			pidff_pkg::REG_KD:          gain_d = longint'(val[pidff_pkg::GAIN_W-1:0]);
			pidff_pkg::REG_UPPER_LIMIT: ceil_q = longint'($signed(val));
			pidff_pkg::REG_LOWER_FLOOR: floor_q = longint'($signed(val));
			pidff_pkg::REG_DERIV_MODE:  angle_mode = val[0];
			pidff_pkg::REG_FIXED_DELTA: delta_fixed = longint'($signed(val));
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Q16.16 value: mostly full range or a few hundred units around zero,
	// sometimes a fraction or one of the corner values.
	function automatic logic [pidff_pkg::DATA_W-1:0] pick_q();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
			8: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
			default: begin
				case ($urandom_range(3))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Gain: zero, full scale, junk in the unused upper bits, or a modest value
	function automatic logic [pidff_pkg::DATA_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return GAIN_MAX;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0003_0000);
		endcase
	endfunction

	function automatic pidff_pkg::in_item_t step_item(input logic [pidff_pkg::DATA_W-1:0] sp,
			input logic [pidff_pkg::DATA_W-1:0] ms, input logic [pidff_pkg::DATA_W-1:0] ff);
		pidff_pkg::in_item_t it;
		it.cmd         = pidff_pkg::CMD_STEP;
		it.setpoint    = sp;
		it.measured    = ms;
		it.feedforward = ff;
		return it;
	endfunction

	// bias steers the error to one sign at near full scale to drive the
	// integral into saturation; zero gives free random items with some clears.
	function automatic pidff_pkg::in_item_t make_item(input int bias);
		pidff_pkg::in_item_t it;
		logic [pidff_pkg::DATA_W-1:0] hi_val, lo_val;
		if (bias != 0 && $urandom_range(9) != 0) begin
			hi_val = Q_MAX - $urandom_range(0, 32'h00FF_FFFF);
			lo_val = Q_MIN + $urandom_range(0, 32'h00FF_FFFF);
			if (bias > 0)
				it = step_item(hi_val, lo_val, pick_q());
			else
				it = step_item(lo_val, hi_val, pick_q());
		end else begin
			it = step_item(pick_q(), pick_q(), pick_q());
			if (bias == 0 && $urandom_range(31) == 0)
				it.cmd = pidff_pkg::CMD_CLEAR;
		end
		return it;
	endfunction

	task automatic random_config(input int bias);
		logic [pidff_pkg::DATA_W-1:0] hi_lim, lo_lim;
		case ($urandom_range(5))
			0, 1: begin
				hi_lim = Q_MAX;
				lo_lim = Q_MIN;
			end
			2: begin
				hi_lim = pick_q();
				lo_lim = pick_q();
			end
			3: begin
				hi_lim = pidff_pkg::UPPER_RESET;
				lo_lim = pidff_pkg::FLOOR_RESET;
			end
			default: begin
				// inverted extremes: almost everything goes to the ceiling
				hi_lim = Q_MIN;
				lo_lim = Q_MAX;
			end
		endcase
		// windup runs need the widest window to show where the integral sits
		if (bias != 0) begin
			hi_lim = Q_MAX;
			lo_lim = Q_MIN;
		end
		write_reg(pidff_pkg::REG_KP, pick_gain());
		write_reg(pidff_pkg::REG_KI, (bias != 0) ? GAIN_MAX : pick_gain());
		write_reg(pidff_pkg::REG_KD, pick_gain());
		write_reg(pidff_pkg::REG_UPPER_LIMIT, hi_lim);
		write_reg(pidff_pkg::REG_LOWER_FLOOR, lo_lim);
		write_reg(pidff_pkg::REG_DERIV_MODE, $urandom);
		write_reg(pidff_pkg::REG_FIXED_DELTA, pick_q());
	endtask

	// Let the queued items through under the given idling and stalling, then wait until
	// every result is in and the pipe has had time to empty.
	task automatic play_phase(input int mode);
		idle_pct  = IDLE_MODE[mode % 4];
		stall_pct = STALL_MODE[mode % 4];
		do
			@(posedge clk);
		while (step_queue.size() != 0 || in_valid || drive_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Driver: new payload only once the current one is taken; valid never
	// looks at in_stall. Receiver stall is redrawn every cycle.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (!in_valid || item_taken) begin
			if (step_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_item  <= step_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check the result leaving at this edge, then predict for the
	// item entering at this edge.
	always @(posedge clk) begin
		pidff_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					fail_count++;
					$error("unexpected result: drive %0d limit_hit %0d",
						$signed(out_item.drive), out_item.limit_hit);
				end else begin
					want = drive_expected.pop_front();
					if (out_item.drive !== want.drive) begin
						fail_count++;
						$error("drive: expected %0d, got %0d",
							$signed(want.drive), $signed(out_item.drive));
					end
					if (out_item.limit_hit !== want.limit_hit) begin
						fail_count++;
						$error("limit_hit: expected %0d, got %0d",
							want.limit_hit, out_item.limit_hit);
					end
				end
			end
			item_taken = in_valid && !in_stall;
			if (item_taken && advance_pid(in_item, want))
				drive_expected.push_back(want);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				cycle_count, drive_expected.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int bias;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero gains, so drive is the feedforward clamped
		// between 150.0 and 1000.0. Below floor, inside, above ceiling, corners.
		step_queue.push_back(step_item(pick_q(), pick_q(), '0));
		step_queue.push_back(step_item(pick_q(), pick_q(), 32'd32768000));
		step_queue.push_back(step_item(pick_q(), pick_q(), 32'd131072000));
		step_queue.push_back(step_item(pick_q(), pick_q(), Q_MAX));
		step_queue.push_back(step_item(pick_q(), pick_q(), Q_MIN));
		step_queue.push_back(step_item(pick_q(), pick_q(), '0) | {pidff_pkg::CMD_CLEAR, 96'd0});
		play_phase(0);

		// Full-scale gains, widest window, speed mode: largest errors both ways,
		// and a clear between so the error difference restarts from zero.
		write_reg(pidff_pkg::REG_KP, GAIN_MAX);
		write_reg(pidff_pkg::REG_KI, GAIN_MAX);
		write_reg(pidff_pkg::REG_KD, GAIN_MAX);
		write_reg(pidff_pkg::REG_UPPER_LIMIT, Q_MAX);
		write_reg(pidff_pkg::REG_LOWER_FLOOR, Q_MIN);
		write_reg(pidff_pkg::REG_DERIV_MODE, pidff_pkg::MODE_SPEED);
		write_reg(pidff_pkg::REG_FIXED_DELTA, Q_MIN);
		step_queue.push_back(step_item(Q_MAX, Q_MIN, Q_MAX));
		step_queue.push_back(step_item(Q_MIN, Q_MAX, Q_MIN));
		step_queue.push_back(step_item('0, '0, '0));
		step_queue.push_back(step_item('0, '0, '0) | {pidff_pkg::CMD_CLEAR, 96'd0});
		step_queue.push_back(step_item(Q_MAX, Q_MIN, '0));
		step_queue.push_back(step_item(Q_MIN, Q_MAX, '0));
		play_phase(0);

		// Angle mode, derivative only: D is the fixed delta at both extremes.
		// The spare index must leave everything as it was.
		write_reg(pidff_pkg::REG_DERIV_MODE, pidff_pkg::MODE_ANGLE);
		write_reg(pidff_pkg::REG_FIXED_DELTA, Q_MAX);
		write_reg(pidff_pkg::REG_KP, '0);
		write_reg(pidff_pkg::REG_KI, '0);
		write_reg(pidff_pkg::REG_KD, Q_ONE);
		write_reg(REG_SPARE, '1);
		step_queue.push_back(step_item(Q_ONE, '0, '0));
		step_queue.push_back(step_item('0, Q_ONE, Q_ONE));
		play_phase(0);
		write_reg(pidff_pkg::REG_FIXED_DELTA, Q_MIN);
		step_queue.push_back(step_item('0, '0, '0));
		play_phase(0);

		// Floor above ceiling (200.0 vs 100.0): only sums over the ceiling
		// take it, everything else lands on the floor.
		write_reg(pidff_pkg::REG_DERIV_MODE, pidff_pkg::MODE_SPEED);
		write_reg(pidff_pkg::REG_KD, '0);
		write_reg(pidff_pkg::REG_UPPER_LIMIT, 32'd6553600);
		write_reg(pidff_pkg::REG_LOWER_FLOOR, 32'd13107200);
		step_queue.push_back(step_item('0, '0, 32'd3276800));
		step_queue.push_back(step_item('0, '0, 32'd9830400));
		step_queue.push_back(step_item('0, '0, 32'd19660800));
		play_phase(0);

		// Random phases. Every sixth pair winds the integral up to positive
		// saturation and then drives it back down through the output window.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			bias = (p % 6 == 4) ? 1 : (p % 6 == 5) ? -1 : 0;
			random_config(bias);
			repeat ((bias == 0) ? 100 : 250) step_queue.push_back(make_item(bias));
			play_phase(p);
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
